>>> rtl/core/rat_acc_pkg.sv
`default_nettype none
package rat_acc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_RED,
    S_GCD,
    S_GCD_WAIT,
    S_DIVN,
    S_DIVN_WAIT,
    S_DIVD,
    S_DIVD_WAIT,
    S_MUL_A,
    S_MUL_B,
    S_MUL_D,
    S_SUM,
    S_CHECK,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic flag_zero_den;
    logic set_unit;
    logic gcd_init;
    logic div_gcd;
    logic gcd_step;
    logic div_num;
    logic take_num;
    logic div_den;
    logic take_den;
    logic mul_a;
    logic mul_b;
    logic mul_d;
    logic sum;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic den_zero;
    logic num_zero;
    logic gcd_zero;
    logic unit_done;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/rat_acc_divu.sv
`default_nettype none
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
module rat_acc_divu
  import rat_acc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [63:0]      remainder
);
  logic        busy;
  logic [6:0]  count;
  logic [63:0] dvs;
  logic [64:0] trial;

  assign trial = {remainder, quotient[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= 7'd64;
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (busy) begin
        if (!trial[64]) begin
          remainder <= trial[63:0];
          quotient  <= {quotient[62:0], 1'b1};
        end else begin
          remainder <= {remainder[62:0], quotient[63]};
          quotient  <= {quotient[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/rat_acc_datapath.sv
`default_nettype none
module rat_acc_datapath
  import rat_acc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic [1:0]         op,
  input  wire logic signed [31:0] operand_num,
  input  wire logic signed [31:0] operand_den,
  output logic signed [31:0]      result_num,
  output logic [30:0]             result_den,
  output logic [1:0]              status
);
  localparam logic signed [63:0] Lim = 64'sd1 <<< (VALUE_WIDTH - 1);

  op_t                op_r;
  logic signed [63:0] rn, rd;
  logic [63:0]        mn, md, ga, gb;
  logic               neg;
  logic signed [63:0] p1, p2, pd;
  logic signed [31:0] acc_num;
  logic [30:0]        acc_den;
  logic signed [32:0] mul_x, mul_y;
  logic signed [65:0] prod;
  logic               d_start, d_done;
  logic [63:0]        d_a, d_b, d_q, d_r;

  // The Euclid remainder steps and the two reducing divisions share one divider.
  rat_acc_divu u_div (
    .clk, .rst, .start(d_start), .dividend(d_a), .divisor(d_b),
    .done(d_done), .quotient(d_q), .remainder(d_r)
  );

  always_comb begin
    d_start = cmd.div_gcd || cmd.div_num || cmd.div_den;
    d_a = ga;
    d_b = gb;
    if (cmd.div_num) begin
      d_a = mn;
      d_b = ga;
    end else if (cmd.div_den) begin
      d_a = md;
      d_b = ga;
    end
  end

  // One signed 33x33 multiplier forms the three cross products in turn.
  always_comb begin
    mul_x = {acc_num[31], acc_num};
    mul_y = rd[32:0];
    if (cmd.mul_b) begin
      mul_x = rn[32:0];
      mul_y = {2'b00, acc_den};
    end else if (cmd.mul_d) begin
      mul_x = {2'b00, acc_den};
      mul_y = rd[32:0];
    end
  end

  assign prod = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num <= '0;
      acc_den <= 31'd1;
      status  <= ST_OK;
    end else begin
      if (cmd.capture) begin
        op_r   <= op_t'(op);
        rn     <= 64'(operand_num);
        rd     <= 64'(operand_den);
        status <= ST_OK;
      end
      if (cmd.prep) begin
        neg <= rn[63] ^ rd[63];
        mn  <= rn[63] ? -rn : rn;
        md  <= rd[63] ? -rd : rd;
      end
      if (cmd.flag_zero_den) status <= ST_ZERO_DEN;
      if (cmd.set_unit) begin
        rn <= 64'sd0;
        rd <= 64'sd1;
      end
      if (cmd.gcd_init) begin
        ga <= mn;
        gb <= md;
      end
      if (cmd.gcd_step) begin
        ga <= gb;
        gb <= d_r;
      end
      if (cmd.take_num) rn <= neg ? -$signed(d_q) : $signed(d_q);
      if (cmd.take_den) rd <= $signed(d_q);
      if (cmd.mul_a) p1 <= prod[63:0];
      if (cmd.mul_b) p2 <= prod[63:0];
      if (cmd.mul_d) pd <= prod[63:0];
      if (cmd.sum) begin
        rn <= (op_r == OP_SUB) ? (p1 - p2) : (p1 + p2);
        rd <= pd;
      end
      if (cmd.commit) begin
        if (rn >= -Lim && rn < Lim && rd >= 64'sd1 && rd < Lim) begin
          acc_num <= rn[31:0];
          acc_den <= rd[30:0];
        end else begin
          status <= ST_OVERFLOW;
        end
      end
    end
  end

  always_comb begin
    stat.op        = op_r;
    stat.den_zero  = (rd == 64'sd0);
    stat.num_zero  = (mn == 64'd0);
    stat.gcd_zero  = (gb == 64'd0);
    stat.unit_done = d_done;
  end

  assign result_num = acc_num;
  assign result_den = acc_den;
endmodule
`default_nettype wire

>>> rtl/core/rat_acc_ctrl.sv
`default_nettype none
module rat_acc_ctrl
  import rat_acc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_fire,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  state_t state, state_next;
  logic   second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  // Except for OP_NONE or a zero den, reduction runs once on the operand and, for add/sub, once on the sum.
  always_comb begin
    state_next  = state;
    second_next = second;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next  = S_PREP;
          second_next = 1'b0;
        end
      end
      S_PREP: begin
        if (stat.op == OP_NONE || stat.den_zero) state_next = S_OUT;
        else state_next = S_RED;
      end
      S_RED: begin
        if (!stat.num_zero) state_next = S_GCD;
        else if (second || stat.op == OP_LOAD) state_next = S_CHECK;
        else state_next = S_MUL_A;
      end
      S_GCD:       state_next = stat.gcd_zero ? S_DIVN : S_GCD_WAIT;
      S_GCD_WAIT:  if (stat.unit_done) state_next = S_GCD;
      S_DIVN:      state_next = S_DIVN_WAIT;
      S_DIVN_WAIT: if (stat.unit_done) state_next = S_DIVD;
      S_DIVD:      state_next = S_DIVD_WAIT;
      S_DIVD_WAIT: begin
        if (stat.unit_done) begin
          if (second || stat.op == OP_LOAD) state_next = S_CHECK;
          else state_next = S_MUL_A;
        end
      end
      S_MUL_A:     state_next = S_MUL_B;
      S_MUL_B:     state_next = S_MUL_D;
      S_MUL_D:     state_next = S_SUM;
      S_SUM: begin
        second_next = 1'b1;
        state_next  = S_PREP;
      end
      S_CHECK:     state_next = S_OUT;
      S_OUT:       if (out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    cmd.capture = in_fire;
    unique case (state)
      S_PREP: begin
        cmd.prep          = 1'b1;
        cmd.flag_zero_den = (stat.op != OP_NONE) && stat.den_zero;
      end
      S_RED: begin
        cmd.set_unit = stat.num_zero;
        cmd.gcd_init = !stat.num_zero;
      end
      S_GCD:       cmd.div_gcd  = !stat.gcd_zero;
      S_GCD_WAIT:  cmd.gcd_step = stat.unit_done;
      S_DIVN:      cmd.div_num  = 1'b1;
      S_DIVN_WAIT: cmd.take_num = stat.unit_done;
      S_DIVD:      cmd.div_den  = 1'b1;
      S_DIVD_WAIT: cmd.take_den = stat.unit_done;
      S_MUL_A:     cmd.mul_a    = 1'b1;
      S_MUL_B:     cmd.mul_b    = 1'b1;
      S_MUL_D:     cmd.mul_d    = 1'b1;
      S_SUM:       cmd.sum      = 1'b1;
      S_CHECK:     cmd.commit   = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/core/rational_accumulator_add_sub_core.sv
// An unused opcode or a zero denominator goes from prep straight to the output. Otherwise each Euclid
// remainder step and each of the two reducing divisions runs on the shared iterative divider;
// a load reduces once, and an add or subtract reduces the operand and then the sum.
// Throughput: one item at a time; the next item is taken after the result leaves.
// Reset (rst, synchronous): accumulator becomes 0/1, controller goes idle.
`default_nettype none
module rational_accumulator_add_sub_core
  import rat_acc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         op,
  input  wire logic signed [31:0] operand_num,
  input  wire logic signed [31:0] operand_den,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      result_num,
  output logic [30:0]             result_den,
  output logic [1:0]              status
);
  cmd_t  cmd;
  stat_t stat;

  rat_acc_ctrl u_ctrl (
    .clk, .rst, .in_fire(in_valid && in_ready), .in_ready, .out_valid,
    .out_ready, .stat, .cmd
  );

  rat_acc_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst, .cmd, .stat, .op, .operand_num, .operand_den,
    .result_num, .result_den, .status
  );
endmodule
`default_nettype wire

>>> sim/tb_rational_accumulator_add_sub_core.sv
`default_nettype none
module tb_rational_accumulator_add_sub_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rat_acc_pkg::*;

  localparam int VW = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = OP_LOAD;
  logic signed [31:0] operand_num = '0;
  logic signed [31:0] operand_den = 32'sd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result_num;
  logic [30:0] result_den;
  logic [1:0] status;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0] den;
    status_t st;
  } frac_result_t;

  frac_result_t pending_fracs[$];
  longint acc_n = 0;
  longint acc_d = 1;
  int errors = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  rational_accumulator_add_sub_core #(.VALUE_WIDTH(VW)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #1000ms;
    $display("rational_accumulator_add_sub_core regression: fail");
    $finish;
  end

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Lowest terms, positive denominator; magnitudes stay below 2^63.
  task automatic reduce_frac(inout longint n, inout longint d);
    bit neg;
    longint unsigned mn, md, g;
    neg = (n < 0) ^ (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    if (mn == 0) begin
      n = 0;
      d = 1;
    end else begin
      g = euclid_gcd(mn, md);
      mn = mn / g;
      md = md / g;
      n = neg ? -longint'(mn) : longint'(mn);
      d = longint'(md);
    end
  endtask

  task automatic predict_acc(logic [1:0] o, logic signed [31:0] a, logic signed [31:0] b);
    longint on, od, rn, rd, lim;
    frac_result_t r;
    status_t st;
    st = ST_OK;
    lim = longint'(1) << (VW - 1);
    if (o != OP_NONE) begin
      if (b == 0) begin
        st = ST_ZERO_DEN;
      end else begin
        on = a;
        od = b;
        reduce_frac(on, od);
        if (o == OP_LOAD) begin
          rn = on;
          rd = od;
        end else begin
          if (o == OP_SUB) on = -on;
          rn = acc_n * od + on * acc_d;
          rd = acc_d * od;
          reduce_frac(rn, rd);
        end
        if (rn >= -lim && rn < lim && rd >= 1 && rd < lim) begin
          acc_n = rn;
          acc_d = rd;
        end else begin
          st = ST_OVERFLOW;
        end
      end
    end
    r.num = acc_n[31:0];
    r.den = acc_d[30:0];
    r.st = st;
    pending_fracs.push_back(r);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Valid stays high from one item to the next unless a gap is taken.
  task automatic send_item(logic [1:0] o, logic signed [31:0] a, logic signed [31:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    op <= o;
    operand_num <= a;
    operand_den <= b;
    in_valid <= 1'b1;
    predict_acc(o, a, b);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when asked.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        for (n = 0; n < 3000; n++) @(negedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 99) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 9) < 7) || stim_done;
      end
    end
  end

  always @(posedge clk) begin
    frac_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_fracs.size() == 0) begin
        $error("result with no expectation: num %0d den %0d", result_num, result_den);
        errors++;
      end else begin
        e = pending_fracs.pop_front();
        if (result_num !== e.num) begin
          $error("result_num expected %0d got %0d", e.num, result_num);
          errors++;
        end
        if (result_den !== e.den) begin
          $error("result_den expected %0d got %0d", e.den, result_den);
          errors++;
        end
        if (status !== e.st) begin
          $error("status expected %0d got %0d", e.st, status);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_val();
    int p;
    p = $urandom_range(0, 9);
    if (p < 4) return $signed($urandom_range(0, 40)) - 20;
    if (p < 7) return $signed($urandom_range(0, 2000)) - 1000;
    if (p < 8) return 32'sh8000_0000 + $urandom_range(0, 3);
    if (p < 9) return 32'sh7fff_ffff - $urandom_range(0, 3);
    return $urandom();
  endfunction

  task automatic test_directed();
    send_item(OP_LOAD, 32'sh7fff_ffff, 1);
    send_item(OP_LOAD, 32'sh8000_0000, 1);
    send_item(OP_LOAD, 32'sh8000_0000, -1);
    send_item(OP_LOAD, 5, 32'sh8000_0000);
    send_item(OP_LOAD, 1, 32'sh7fff_ffff);
    send_item(OP_LOAD, 0, -7);
    send_item(OP_LOAD, 6, -4);
    send_item(OP_ADD, 1, 0);
    send_item(OP_SUB, 1, 0);
    send_item(OP_LOAD, 3, 0);
    send_item(OP_ADD, 1, 3);
    send_item(OP_SUB, -5, 6);
    send_item(OP_NONE, 9, 0);
    send_item(OP_LOAD, 32'sh7fff_fffe, 1);
    send_item(OP_ADD, 5, 1);
    send_item(OP_LOAD, 1, 65536);
    send_item(OP_ADD, 1, 65537);
    send_item(OP_SUB, 32'sh8000_0000, 32'sh8000_0000);
    send_item(OP_LOAD, -1, 32'sh8000_0000);
    send_item(OP_SUB, 32'sh7fff_ffff, 32'sh8000_0000);
  endtask

  task automatic test_random(int count);
    int p;
    logic [1:0] o;
    repeat (count) begin
      p = $urandom_range(0, 99);
      o = (p < 15) ? OP_LOAD : (p < 55) ? OP_ADD : (p < 95) ? OP_SUB : OP_NONE;
      send_item(o, rand_val(), ($urandom_range(0, 29) == 0) ? 32'sd0 : rand_val());
    end
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_off = 1'b1;
    test_random(8);
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(800);
    test_backpressure();
    test_random(770);
    in_valid <= 1'b0;
    stim_done = 1'b1;
    guard = 0;
    while (pending_fracs.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_fracs.size() == 0) begin
      $display("rational_accumulator_add_sub_core regression: pass");
    end else begin
      $display("rational_accumulator_add_sub_core regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
